// ----- rtl/core/rse_pkg.sv -----
// ----------------------------------------------------------------------------
// rse_pkg
// Shared types and codes for the ring skip elimination block: slot and count
// widths, link word layout, command kinds, result status codes, sequencer
// states.
// ----------------------------------------------------------------------------
package rse_pkg;

  localparam int RING_DEPTH = 16;
  localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int VALUE_W    = 32;
  localparam int SKIP_W     = 8;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [SLOT_W-1:0]         slot_t;
  typedef logic [CNT_W-1:0]          cnt_t;
  typedef logic [SKIP_W-1:0]         skip_t;

  typedef struct packed {
    slot_t prev;
    slot_t next;
  } link_t;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_ELIM   = 2'd1,
    KIND_LIST   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_LAST  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AP_ENTRY,
    S_AP_TAIL,
    S_AP_HEAD,
    S_EL_START,
    S_EL_WALK,
    S_EL_UNLINK_N,
    S_EL_UNLINK_P,
    S_LS_READ,
    S_LS_EMIT,
    S_EMIT
  } state_t;

endpackage

// ----- rtl/core/rse_req_if.sv -----
// ----------------------------------------------------------------------------
// rse_req_if
// Command channel of the ring block: kind, value to append, skip count.
// ----------------------------------------------------------------------------
interface rse_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                kind;
  logic signed [31:0]        value;
  logic [7:0]                skip;

  modport source (output valid, output kind, output value, output skip, input ready);
  modport sink   (input valid, input kind, input value, input skip, output ready);
endinterface

// ----- rtl/core/rse_rsp_if.sv -----
// ----------------------------------------------------------------------------
// rse_rsp_if
// Result channel of the ring block: value, status and end-of-command mark.
// ----------------------------------------------------------------------------
interface rse_rsp_if;
  logic                      valid;
  logic                      ready;
  logic signed [31:0]        result_value;
  logic [1:0]                status;
  logic                      last;

  modport source (output valid, output result_value, output status, output last,
                  input ready);
  modport sink   (input valid, input result_value, input status, input last,
                  output ready);
endinterface

// ----- rtl/core/ring_skip_elimination.sv -----
// ----------------------------------------------------------------------------
// ring_skip_elimination
// Circular doubly linked list of signed values in a fixed slot pool, with
// append, skip-and-eliminate and list commands. Values and links live in two
// synchronous memories walked by a small sequencer.
// ----------------------------------------------------------------------------
//  channel  dir  payload                        transfer when
//  req      in   kind, value, skip              req.valid && req.ready
//  rsp      out  result_value, status, last     rsp.valid && rsp.ready
//
//  one command at a time; req.ready is high only while the sequencer is idle
//  append: entry write, then tail and head links unless the ring was empty
//  eliminate: one link read per link walked; the only entry needs no unlink
//  list: per entry, one value and link read then one result
//  a full result register stalls only the step that loads it
//  reset clears head, tail, cursor, count and slot flags; memories need none
// ----------------------------------------------------------------------------
module ring_skip_elimination (
  input logic     clk,
  input logic     rst,
  rse_req_if.sink   req,
  rse_rsp_if.source rsp
);
  import rse_pkg::*;

  // memories
  value_t val_mem  [RING_DEPTH];
  link_t  link_mem [RING_DEPTH];
  value_t val_rdata;
  link_t  link_rdata;

  logic   val_we, val_re;
  slot_t  val_wa, val_ra;
  value_t val_wd;
  logic   link_we_next, link_we_prev, link_re;
  slot_t  link_wa, link_ra;
  link_t  link_wd;

  // control state
  state_t                state, state_next;
  logic [RING_DEPTH-1:0] in_use;
  slot_t                 head, tail, cursor;
  cnt_t                  count;
  slot_t                 cur, fs, prv, nxt;
  skip_t                 rem;
  cnt_t                  lrem;
  value_t                res_value;
  status_t               res_status;

  // output register
  logic    o_valid;
  value_t  o_value;
  status_t o_status;
  logic    o_last;
  logic    out_load, out_free;
  value_t  out_value_d;
  status_t out_status_d;
  logic    out_last_d;

  logic  acc;
  slot_t free_slot;
  logic  is_full, is_empty;

  assign acc      = req.valid && req.ready;
  assign out_free = !o_valid || rsp.ready;
  assign is_full  = (count == CNT_W'(RING_DEPTH));
  assign is_empty = (count == '0);

  // lowest free slot
  always_comb begin
    free_slot = '0;
    for (int i = RING_DEPTH - 1; i >= 0; i--) begin
      if (!in_use[i]) free_slot = SLOT_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_wa] <= val_wd;
    if (val_re) val_rdata <= val_mem[val_ra];
  end

  always_ff @(posedge clk) begin
    if (link_we_next) link_mem[link_wa].next <= link_wd.next;
    if (link_we_prev) link_mem[link_wa].prev <= link_wd.prev;
    if (link_re)      link_rdata <= link_mem[link_ra];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc) begin
          case (req.kind)
            KIND_APPEND: state_next = is_full ? S_EMIT : S_AP_ENTRY;
            KIND_ELIM:   state_next = is_empty ? S_EMIT : S_EL_START;
            KIND_LIST:   state_next = is_empty ? S_EMIT : S_LS_READ;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_AP_ENTRY:    state_next = is_empty ? S_EMIT : S_AP_TAIL;
      S_AP_TAIL:     state_next = S_AP_HEAD;
      S_AP_HEAD:     state_next = S_EMIT;
      S_EL_START:    state_next = S_EL_WALK;
      S_EL_WALK: begin
        if (rem == '0) state_next = (count == cnt_t'(1)) ? S_EMIT : S_EL_UNLINK_N;
      end
      S_EL_UNLINK_N: state_next = S_EL_UNLINK_P;
      S_EL_UNLINK_P: state_next = S_EMIT;
      S_LS_READ:     state_next = S_LS_EMIT;
      S_LS_EMIT: begin
        if (out_free) state_next = (lrem == cnt_t'(1)) ? S_IDLE : S_LS_READ;
      end
      S_EMIT: begin
        if (out_free) state_next = S_IDLE;
      end
      default:       state_next = S_IDLE;
    endcase
  end

  // memory controls and result loads
  always_comb begin
    val_we       = 1'b0;
    val_wa       = fs;
    val_wd       = res_value;
    val_re       = 1'b0;
    val_ra       = cur;
    link_we_next = 1'b0;
    link_we_prev = 1'b0;
    link_wa      = fs;
    link_wd      = '{prev: tail, next: head};
    link_re      = 1'b0;
    link_ra      = cur;
    out_load     = 1'b0;
    out_value_d  = res_value;
    out_status_d = res_status;
    out_last_d   = 1'b1;
    case (state)
      S_AP_ENTRY: begin
        val_we       = 1'b1;
        link_we_next = 1'b1;
        link_we_prev = 1'b1;
        if (is_empty) link_wd = '{prev: fs, next: fs};
      end
      S_AP_TAIL: begin
        link_we_next = 1'b1;
        link_wa      = tail;
        link_wd      = '{prev: fs, next: fs};
      end
      S_AP_HEAD: begin
        link_we_prev = 1'b1;
        link_wa      = head;
        link_wd      = '{prev: fs, next: fs};
      end
      S_EL_START: link_re = 1'b1;
      S_EL_WALK: begin
        if (rem != '0) begin
          link_re = 1'b1;
          link_ra = link_rdata.next;
        end
      end
      S_EL_UNLINK_N: begin
        link_we_next = 1'b1;
        link_wa      = prv;
        link_wd      = '{prev: prv, next: nxt};
        val_re       = 1'b1;
        val_ra       = nxt;
      end
      S_EL_UNLINK_P: begin
        link_we_prev = 1'b1;
        link_wa      = nxt;
        link_wd      = '{prev: prv, next: nxt};
      end
      S_LS_READ: begin
        val_re  = 1'b1;
        link_re = 1'b1;
      end
      S_LS_EMIT: begin
        out_load     = out_free;
        out_value_d  = val_rdata;
        out_status_d = ST_OK;
        out_last_d   = (lrem == cnt_t'(1));
      end
      S_EMIT:  out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      in_use <= '0;
      head   <= '0;
      tail   <= '0;
      cursor <= '0;
      count  <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_AP_ENTRY: begin
          if (is_empty) begin
            head       <= fs;
            tail       <= fs;
            cursor     <= fs;
            count      <= count + cnt_t'(1);
            in_use[fs] <= 1'b1;
          end
        end
        S_AP_HEAD: begin
          tail       <= fs;
          cursor     <= head;
          count      <= count + cnt_t'(1);
          in_use[fs] <= 1'b1;
        end
        S_EL_WALK: begin
          if (rem == '0 && count == cnt_t'(1)) begin
            in_use[cur] <= 1'b0;
            head        <= '0;
            tail        <= '0;
            cursor      <= '0;
            count       <= '0;
          end
        end
        S_EL_UNLINK_P: begin
          in_use[cur] <= 1'b0;
          if (cur == head) head <= nxt;
          if (cur == tail) tail <= prv;
          cursor <= nxt;
          count  <= count - cnt_t'(1);
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        fs         <= free_slot;
        cur        <= (req.kind == KIND_LIST) ? head : cursor;
        rem        <= req.skip;
        lrem       <= count;
        res_value  <= (req.kind == KIND_APPEND && !is_full) ? req.value : value_t'(0);
        if (req.kind == KIND_APPEND) begin
          res_status <= is_full ? ST_FULL : ST_OK;
        end else begin
          res_status <= is_empty ? ST_EMPTY : ST_OK;
        end
      end
      S_EL_WALK: begin
        if (rem != '0) begin
          // follow one link per cycle
          cur <= link_rdata.next;
          rem <= rem - skip_t'(1);
        end else begin
          prv <= link_rdata.prev;
          nxt <= link_rdata.next;
          if (count == cnt_t'(1)) begin
            res_value  <= '0;
            res_status <= ST_LAST;
          end
        end
      end
      S_EL_UNLINK_P: begin
        res_value  <= val_rdata;
        res_status <= ST_OK;
      end
      S_LS_EMIT: begin
        if (out_free) begin
          cur  <= link_rdata.next;
          lrem <= lrem - cnt_t'(1);
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_load) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_value  <= out_value_d;
      o_status <= out_status_d;
      o_last   <= out_last_d;
    end
  end

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = o_valid;
  assign rsp.result_value = o_value;
  assign rsp.status       = o_status;
  assign rsp.last         = o_last;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(RING_DEPTH))
    else $error("entry count above ring depth");

  a_flags_match_count: assert property (@(posedge clk) disable iff (rst)
    $countones(in_use) == int'(count))
    else $error("slot flags disagree with entry count");

  a_list_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_LS_EMIT |-> lrem != '0)
    else $error("list step with no entries left");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!o_valid || rsp.ready))
    else $error("result register overwritten before transfer");

endmodule

// ----- tb/sv/rse_ring_checker.sv -----
// ----------------------------------------------------------------------------
// rse_ring_checker
// Watches the command and result channels of the ring block, keeps its own
// copy of the slot pool, links, head, tail and cursor, works out the results
// of every accepted command and compares them in order with the results that
// come out. Hands the failure count and the number of outstanding results up.
// ----------------------------------------------------------------------------
module rse_ring_checker
  import rse_pkg::*;
(
  input  logic clk,
  input  logic rst,
  rse_req_if   req,
  rse_rsp_if   rsp,
  output int   fail_count,
  output int   pending,
  output int   checked
);

  typedef struct packed {
    value_t  result_value;
    status_t status;
    logic    last;
  } ring_result_t;

  value_t                slot_value [RING_DEPTH];
  slot_t                 slot_next  [RING_DEPTH];
  slot_t                 slot_prev  [RING_DEPTH];
  logic [RING_DEPTH-1:0] slot_used;
  slot_t                 head;
  slot_t                 tail;
  slot_t                 cursor;
  cnt_t                  count;
  ring_result_t          pending_results [$];
  ring_result_t          want;
  int                    n_fail = 0;
  int                    n_checked = 0;

  function automatic void queue_result(value_t v, status_t st, logic lst);
    ring_result_t r;
    r.result_value = v;
    r.status       = st;
    r.last         = lst;
    pending_results.push_back(r);
  endfunction

  function automatic void ring_apply(kind_t k, value_t v, skip_t s);
    slot_t c;
    slot_t p;
    slot_t nx;
    int    fs;
    int    i;
    case (k)
      KIND_APPEND: begin
        if (count >= RING_DEPTH) begin
          queue_result('0, ST_FULL, 1'b1);
          return;
        end
        // lowest free slot takes the new entry
        fs = 0;
        while (slot_used[fs]) fs++;
        slot_value[fs] = v;
        slot_used[fs]  = 1'b1;
        if (count == 0) begin
          slot_next[fs] = slot_t'(fs);
          slot_prev[fs] = slot_t'(fs);
          head          = slot_t'(fs);
        end else begin
          slot_next[tail] = slot_t'(fs);
          slot_prev[fs]   = tail;
          slot_next[fs]   = head;
          slot_prev[head] = slot_t'(fs);
        end
        tail   = slot_t'(fs);
        count  = count + 1'b1;
        cursor = head;
        queue_result(v, ST_OK, 1'b1);
      end
      KIND_ELIM: begin
        if (count == 0) begin
          queue_result('0, ST_EMPTY, 1'b1);
          return;
        end
        c = cursor;
        for (i = 0; i < s; i++) c = slot_next[c];
        slot_used[c] = 1'b0;
        if (count == 1) begin
          count  = '0;
          head   = '0;
          tail   = '0;
          cursor = '0;
          queue_result('0, ST_LAST, 1'b1);
          return;
        end
        p  = slot_prev[c];
        nx = slot_next[c];
        slot_next[p]  = nx;
        slot_prev[nx] = p;
        if (c == head) head = nx;
        if (c == tail) tail = p;
        count  = count - 1'b1;
        cursor = nx;
        queue_result(slot_value[nx], ST_OK, 1'b1);
      end
      KIND_LIST: begin
        if (count == 0) begin
          queue_result('0, ST_EMPTY, 1'b1);
          return;
        end
        c = head;
        for (i = 0; i < count; i++) begin
          queue_result(slot_value[c], ST_OK, (i == count - 1));
          c = slot_next[c];
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      slot_used = '0;
      head      = '0;
      tail      = '0;
      cursor    = '0;
      count     = '0;
      pending_results.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing outstanding: result_value %0d status %0d last %0d",
                 rsp.result_value, rsp.status, rsp.last);
          n_fail++;
        end else begin
          want = pending_results.pop_front();
          n_checked++;
          if (rsp.result_value !== want.result_value) begin
            $error("result_value: expected %0d, got %0d", want.result_value,
                   rsp.result_value);
            n_fail++;
          end
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            n_fail++;
          end
          if (rsp.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, rsp.last);
            n_fail++;
          end
        end
      end
      if (req.valid && req.ready) ring_apply(kind_t'(req.kind), req.value, req.skip);
    end
    fail_count <= n_fail;
    pending    <= pending_results.size();
    checked    <= n_checked;
  end

endmodule

// ----- tb/sv/tb_ring_skip_elimination.sv -----
// ----------------------------------------------------------------------------
// tb_ring_skip_elimination
// Drives append, eliminate and list commands into the ring block: a directed
// run over empty, single-entry and full rings and the field extremes, then
// random commands in runs that lean toward filling or draining the ring,
// under three idling mixes and one long result hold-off. Checking is done by
// rse_ring_checker; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_ring_skip_elimination;
  import rse_pkg::*;

  localparam int LIMIT            = 1_000_000;
  localparam int LONG_HOLD        = 400;
  localparam int DRAIN            = 300;
  localparam int RANDOM_PER_PHASE = 45;
  localparam int BIAS_RUN         = 28;

  logic clk = 1'b0;
  logic rst;
  logic hold_go = 1'b0;
  int   snd_idle_pct = 0;
  int   rcv_idle_pct = 0;
  int   hold_cnt = 0;
  int   cycle_cnt = 0;
  int   fail_count;
  int   pending;
  int   checked;
  int   n_sent [4] = '{default: 0};

  rse_req_if req ();
  rse_rsp_if rsp ();

  ring_skip_elimination uut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  rse_ring_checker chk (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .fail_count(fail_count),
    .pending(pending),
    .checked(checked)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("ring_skip_elimination: mismatch");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off once hold_go is set
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && hold_cnt < LONG_HOLD) begin
        hold_cnt++;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  task automatic issue(kind_t k, value_t v, skip_t s);
    if ($urandom_range(99) < snd_idle_pct) begin
      req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    req.valid <= 1'b1;
    req.kind  <= k;
    req.value <= v;
    req.skip  <= s;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    n_sent[int'(k)]++;
  endtask

  // runs alternate between leaning toward appends and toward eliminations
  task automatic run_random(int n);
    int     done;
    int     r;
    int     append_pct;
    kind_t  k;
    value_t v;
    skip_t  s;
    done = 0;
    while (done < n) begin
      append_pct = ((done / BIAS_RUN) % 2 == 0) ? 60 : 25;
      r = $urandom_range(99);
      if (r < 5)                   k = KIND_NONE;
      else if (r < 5 + append_pct) k = KIND_APPEND;
      else if (r < 85)             k = KIND_ELIM;
      else                         k = KIND_LIST;
      case ($urandom_range(7))
        0:       v = value_t'(32'h8000_0000);
        1:       v = value_t'(32'h7fff_ffff);
        2:       v = '1;
        default: v = value_t'($urandom);
      endcase
      s = ($urandom_range(3) == 0) ? skip_t'($urandom_range(255))
                                   : skip_t'($urandom_range(20));
      issue(k, v, s);
      if (k != KIND_NONE) done++;
    end
  endtask

  initial begin
    int     i;
    value_t v;
    rst       = 1'b1;
    req.valid = 1'b0;
    req.kind  = KIND_NONE;
    req.value = '0;
    req.skip  = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    snd_idle_pct = 22;
    rcv_idle_pct <= 60;

    // empty ring, then a single entry removed by a long walk around itself
    issue(KIND_LIST, '0, '0);
    issue(KIND_ELIM, '0, skip_t'(9));
    issue(KIND_APPEND, value_t'(32'h8000_0000), '0);
    issue(KIND_ELIM, '0, skip_t'(255));
    issue(KIND_NONE, '1, '1);
    // fill to capacity, overflow, list the full ring
    for (i = 0; i < RING_DEPTH; i++) begin
      case (i)
        0:       v = value_t'(32'h7fff_ffff);
        1:       v = '1;
        2:       v = '0;
        3:       v = value_t'(1);
        default: v = value_t'($urandom);
      endcase
      issue(KIND_APPEND, v, '0);
    end
    issue(KIND_APPEND, value_t'(5), '0);
    issue(KIND_LIST, '0, '0);
    // remove the head, then the tail, then a wrap-around walk
    issue(KIND_ELIM, '0, '0);
    issue(KIND_ELIM, '0, skip_t'(RING_DEPTH - 2));
    issue(KIND_ELIM, '0, skip_t'(255));
    issue(KIND_LIST, '0, '0);

    run_random(RANDOM_PER_PHASE);
    snd_idle_pct = 60;
    rcv_idle_pct <= 22;
    run_random(RANDOM_PER_PHASE);
    snd_idle_pct = 0;
    rcv_idle_pct <= 0;
    hold_go      <= 1'b1;
    run_random(RANDOM_PER_PHASE);
    req.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("covered %0d appends, %0d eliminations, %0d lists, %0d ignored commands",
             n_sent[KIND_APPEND], n_sent[KIND_ELIM], n_sent[KIND_LIST], n_sent[KIND_NONE]);
    $display("%0d results compared, one result hold-off of %0d cycles", checked, LONG_HOLD);
    if (fail_count == 0) begin
      $display("ring_skip_elimination: match");
    end else begin
      $display("ring_skip_elimination: mismatch");
    end
    $finish;
  end

endmodule
